/* hw/rtl/gbag_pkg.sv */
// Shared types, constants and helpers for the glyph blit address generator
`timescale 1ns / 1ps
`default_nettype none

package gbag_pkg;

    // character code space
    localparam int CODE_BITS  = 16;
    localparam int CODE_COUNT = 1 << CODE_BITS;

    typedef logic [CODE_BITS-1:0] code_t;

    localparam code_t CODE_MASK  = code_t'(CODE_COUNT - 1);
    localparam code_t CH_NEWLINE = code_t'(10);
    localparam code_t CH_TAB     = code_t'(9);

    // cyrillic fold window, compared on the full 16-bit code
    localparam logic [15:0] FOLD_LOW  = 16'h0430;
    localparam logic [15:0] FOLD_HIGH = 16'h044F;
    localparam logic [15:0] FOLD_STEP = 16'h0020;

    // decoupling queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // shared divider
    localparam int DIV_W     = 16;
    localparam int DSR_W     = 12;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // stream widths
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 104;

    // configuration register indexes and reset values
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH = 2'd2;
    localparam logic [7:0]  CELL_WIDTH_RST  = 8'd8;
    localparam logic [7:0]  CELL_HEIGHT_RST = 8'd8;
    localparam logic [11:0] ATLAS_WIDTH_RST = 12'd256;

    // input command codes
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_CHAR  = 2'd2
    } cmd_t;

    // operations handed from front to back
    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_NEWLINE = 2'd1,
        OP_TAB     = 2'd2,
        OP_DRAW    = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] char_code;
        logic [15:0] glyph_index;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
    } item_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] glyph;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
    } entry_t;

    typedef struct packed {
        logic [7:0]  cell_width;
        logic [7:0]  cell_height;
        logic [11:0] atlas_width;
    } cfg_t;

    typedef struct packed {
        logic [31:0] dst_y;
        logic [31:0] dst_x;
        logic [23:0] src_y;
        logic [11:0] src_x;
    } result_t;

    // fold the cyrillic lower-case window down by one step
    function automatic code_t fold_code(input code_t c);
        logic [15:0] w;
        w = 16'(c);
        if (w >= FOLD_LOW && w <= FOLD_HIGH)
        begin
            w = w - FOLD_STEP;
        end
        return w[CODE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/glyph_blit_address_generator.sv */
// Top level: configuration registers, stream packing and front/back hookup
//
//  channel  | direction | fields (low bit first)
//  s_axis   | in        | tuser: cmd; tdata: char_code, glyph_index, origin_x, origin_y
//  m_axis   | out       | tdata: src_x, src_y, dst_x, dst_y, 4 zero bits
//  cfg      | in        | cfg_index 0 cell_width, 1 cell_height, 2 atlas_width
//
// After reset the glyph table is cleared, one entry a cycle, with s_axis_tready
// low; configuration writes are taken throughout.
// A drawn glyph in atlas row zero skips the row split; any other glyph runs it
// on the 16-step shared divider, and the first glyph after a cell_width or
// atlas_width write first works out glyphs per row on the same divider.
// The four-entry queue and the output register let either side stall alone.
`timescale 1ns / 1ps
`default_nettype none

module glyph_blit_address_generator (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // cmd
    input  wire logic [gbag_pkg::IN_TUSER_W-1:0]       s_axis_tuser,
    // char_code, glyph_index, origin_x, origin_y
    input  wire logic [gbag_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // src_x, src_y, dst_x, dst_y, zero pad
    output logic [gbag_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    input  wire logic                                  cfg_we,
    input  wire logic [gbag_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [gbag_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import gbag_pkg::*;

    cfg_t    cfg_reg, cfg_next;
    logic    geom_wr;
    item_t   in_item;
    logic    q_push;
    entry_t  q_wr_entry;
    logic    q_ready;
    logic    q_pop;
    entry_t  q_rd_entry;
    logic    q_valid;
    result_t result;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        geom_wr  = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CELL_WIDTH:
                begin
                    cfg_next.cell_width = cfg_data[7:0];
                    geom_wr             = 1'b1;
                end
                REG_CELL_HEIGHT:
                begin
                    cfg_next.cell_height = cfg_data[7:0];
                end
                REG_ATLAS_WIDTH:
                begin
                    cfg_next.atlas_width = cfg_data[11:0];
                    geom_wr              = 1'b1;
                end
                default:
                begin
                    geom_wr = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_width  <= CELL_WIDTH_RST;
            cfg_reg.cell_height <= CELL_HEIGHT_RST;
            cfg_reg.atlas_width <= ATLAS_WIDTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // unpack the input transfer
    assign in_item.cmd         = s_axis_tuser;
    assign in_item.char_code   = s_axis_tdata[15:0];
    assign in_item.glyph_index = s_axis_tdata[31:16];
    assign in_item.origin_x    = s_axis_tdata[47:32];
    assign in_item.origin_y    = s_axis_tdata[63:48];

    gbag_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_push   (q_push),
        .q_entry  (q_wr_entry),
        .q_ready  (q_ready)
    );

    gbag_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .ready    (q_ready),
        .pop      (q_pop),
        .rd_entry (q_rd_entry),
        .valid    (q_valid)
    );

    gbag_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .geom_wr   (geom_wr),
        .q_valid   (q_valid),
        .q_entry   (q_rd_entry),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

    // pack the output transfer
    assign m_axis_tdata = {4'd0, result.dst_y, result.dst_x, result.src_y, result.src_x};

endmodule

`default_nettype wire

/* hw/rtl/gbag_div.sv */
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module gbag_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [gbag_pkg::DIV_W-1:0]   dividend,
    input  wire logic [gbag_pkg::DSR_W-1:0]   divisor,
    output logic                              busy,
    output logic                              done,
    output logic [gbag_pkg::DIV_W-1:0]        quotient,
    output logic [gbag_pkg::DSR_W-1:0]        remainder
);
    import gbag_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DSR_W-1:0]     rem_reg, rem_next;
    logic [DSR_W-1:0]     dsr_reg, dsr_next;
    logic [DSR_W:0]       shifted;
    logic [DSR_W:0]       trial;

    // one shift and trial subtract per step
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DIV_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DSR_W])
            begin
                rem_next = trial[DSR_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DSR_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* hw/rtl/gbag_front.sv */
// Front end: accepts items, owns the glyph table, classifies character items
`timescale 1ns / 1ps
`default_nettype none

module gbag_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire gbag_pkg::item_t  in_item,
    output logic                  q_push,
    output gbag_pkg::entry_t      q_entry,
    input  wire logic             q_ready
);
    import gbag_pkg::*;

    logic [15:0] glyph_mem [0:CODE_COUNT-1];
    logic [15:0] rd_data_reg;

    logic        clearing_reg, clearing_next;
    code_t       clr_cnt_reg, clr_cnt_next;
    logic        s1_valid_reg, s1_valid_next;
    op_t         s1_op_reg, s1_op_next;
    logic [15:0] s1_ox_reg, s1_oy_reg;

    logic        accept;
    code_t       code;
    logic        mem_we;
    code_t       mem_waddr;
    logic [15:0] mem_wdata;
    logic        mem_re;
    code_t       mem_raddr;
    logic        make_entry;
    op_t         new_op;

    assign in_ready = !clearing_reg && (!s1_valid_reg || q_ready);
    assign accept   = in_valid && in_ready;
    assign code     = in_item.char_code[CODE_BITS-1:0];
    assign q_push   = s1_valid_reg && q_ready;

    // classify the accepted item
    always_comb
    begin
        mem_we     = 1'b0;
        mem_waddr  = code;
        mem_wdata  = in_item.glyph_index;
        mem_re     = 1'b0;
        mem_raddr  = fold_code(code);
        make_entry = 1'b0;
        new_op     = OP_START;
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (accept)
        begin
            case (in_item.cmd)
                CMD_LOAD:
                begin
                    mem_we = (code != CH_NEWLINE) && (code != CODE_MASK);
                end
                CMD_START:
                begin
                    make_entry = 1'b1;
                    new_op     = OP_START;
                end
                CMD_CHAR:
                begin
                    make_entry = 1'b1;
                    if (code == CH_NEWLINE)
                    begin
                        new_op = OP_NEWLINE;
                    end
                    else if (code == CH_TAB)
                    begin
                        new_op = OP_TAB;
                    end
                    else
                    begin
                        new_op = OP_DRAW;
                        mem_re = 1'b1;
                    end
                end
                default:
                begin
                    make_entry = 1'b0;
                end
            endcase
        end
    end

    // clearing pass and stage one control
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CODE_MASK)
            begin
                clearing_next = 1'b0;
            end
        end
        s1_valid_next = s1_valid_reg && !q_push;
        s1_op_next    = s1_op_reg;
        if (make_entry)
        begin
            s1_valid_next = 1'b1;
            s1_op_next    = new_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_op_reg    <= OP_START;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
            s1_valid_reg <= s1_valid_next;
            s1_op_reg    <= s1_op_next;
        end
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (make_entry)
        begin
            s1_ox_reg <= in_item.origin_x;
            s1_oy_reg <= in_item.origin_y;
        end
    end

    // glyph table, one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            glyph_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= glyph_mem[mem_raddr];
        end
    end

    assign q_entry.op       = s1_op_reg;
    assign q_entry.glyph    = rd_data_reg;
    assign q_entry.origin_x = s1_ox_reg;
    assign q_entry.origin_y = s1_oy_reg;

endmodule

`default_nettype wire

/* hw/rtl/gbag_queue.sv */
// Short queue between the front and back ends
`timescale 1ns / 1ps
`default_nettype none

module gbag_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire gbag_pkg::entry_t  wr_entry,
    output logic                   ready,
    input  wire logic              pop,
    output gbag_pkg::entry_t       rd_entry,
    output logic                   valid
);
    import gbag_pkg::*;

    entry_t               slot_reg [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                 do_push;
    logic                 do_pop;

    assign ready   = cnt_reg != Q_CNT_W'(Q_DEPTH);
    assign valid   = cnt_reg != '0;
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    assign rd_entry = slot_reg[rd_ptr_reg];

endmodule

`default_nettype wire

/* hw/rtl/gbag_back.sv */
// Back end: cursor state, glyph split and result register
`timescale 1ns / 1ps
`default_nettype none

module gbag_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gbag_pkg::cfg_t    cfg,
    input  wire logic              geom_wr,
    input  wire logic              q_valid,
    input  wire gbag_pkg::entry_t  q_entry,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output gbag_pkg::result_t      out_data
);
    import gbag_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PREP  = 6'b000010,
        ST_CHECK = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_MUL   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] cur_x_reg, cur_x_next;
    logic [31:0] cur_y_reg, cur_y_next;
    logic [15:0] org_x_reg, org_x_next;
    logic        dirty_reg, dirty_next;
    logic [11:0] per_row_reg, per_row_next;
    logic        frac_reg, frac_next;
    logic [15:0] glyph_reg, glyph_next;
    logic [11:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [11:0] src_x_reg, src_x_next;
    logic [23:0] src_y_reg, src_y_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_data_reg, out_data_next;

    logic [11:0] fw_eff;
    logic [23:0] prod;
    logic        fits_row0;
    logic [12:0] lim;
    logic [19:0] col_prod;
    logic        out_free;

    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DSR_W-1:0] div_divisor;
    logic             div_busy;
    logic             div_done;
    logic [DIV_W-1:0] div_quo;
    logic [DSR_W-1:0] div_rem;

    gbag_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // geometry terms
    assign fw_eff    = (cfg.atlas_width == '0) ? 12'd1 : cfg.atlas_width;
    assign prod      = {8'd0, glyph_reg} * {16'd0, cfg.cell_width};
    assign fits_row0 = (cfg.cell_width == '0) || (prod < {12'd0, fw_eff});
    assign lim       = {1'b0, per_row_reg} + {12'd0, frac_reg};
    assign col_prod  = {8'd0, col_reg} * {12'd0, cfg.cell_width};
    assign out_free  = !out_valid_reg || out_ready;
    assign q_pop     = q_valid && (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        org_x_next     = org_x_reg;
        dirty_next     = dirty_reg || geom_wr;
        per_row_next   = per_row_reg;
        frac_next      = frac_reg;
        glyph_next     = glyph_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        src_x_next     = src_x_reg;
        src_y_next     = src_y_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        div_dividend   = {{(DIV_W-12){1'b0}}, fw_eff};
        div_divisor    = {{(DSR_W-8){1'b0}}, cfg.cell_width};
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_entry.op)
                        OP_START:
                        begin
                            cur_x_next = {{16{q_entry.origin_x[15]}}, q_entry.origin_x};
                            cur_y_next = {{16{q_entry.origin_y[15]}}, q_entry.origin_y};
                            org_x_next = q_entry.origin_x;
                        end
                        OP_NEWLINE:
                        begin
                            cur_y_next = cur_y_reg + {24'd0, cfg.cell_height};
                            cur_x_next = {{16{org_x_reg[15]}}, org_x_reg};
                        end
                        OP_TAB:
                        begin
                            cur_x_next = cur_x_reg + {23'd0, cfg.cell_width, 1'b0};
                        end
                        default:
                        begin
                            glyph_next = q_entry.glyph;
                            if (dirty_reg && (cfg.cell_width != '0))
                            begin
                                div_start  = 1'b1;
                                state_next = ST_PREP;
                            end
                            else
                            begin
                                state_next = ST_CHECK;
                            end
                        end
                    endcase
                end
            end
            ST_PREP:
            begin
                // glyphs per row and whether the row limit rounds up
                if (div_done)
                begin
                    per_row_next = (div_quo == '0) ? 12'd1 : div_quo[11:0];
                    frac_next    = (div_quo != '0) && (div_rem != '0);
                    dirty_next   = geom_wr;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (fits_row0)
                begin
                    src_x_next = prod[11:0];
                    src_y_next = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = glyph_reg - {3'd0, lim};
                    div_divisor  = per_row_reg;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    col_next   = div_rem + {11'd0, frac_reg};
                    row_next   = div_quo + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                src_x_next = col_prod[11:0];
                src_y_next = {8'd0, row_reg} * {16'd0, cfg.cell_height};
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cur_x_next          = cur_x_reg + {24'd0, cfg.cell_width};
                    out_valid_next      = 1'b1;
                    out_data_next.src_x = src_x_reg;
                    out_data_next.src_y = src_y_reg;
                    out_data_next.dst_x = cur_x_next;
                    out_data_next.dst_y = cur_y_reg;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            org_x_reg     <= '0;
            dirty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            org_x_reg     <= org_x_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        per_row_reg  <= per_row_next;
        frac_reg     <= frac_next;
        glyph_reg    <= glyph_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        src_x_reg    <= src_x_next;
        src_y_reg    <= src_y_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // divider is running or finishing whenever the sequencer waits on it
    a_div_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV || state_reg == ST_PREP) |-> (div_busy || div_done))
        else $error("sequencer waits on an idle divider");

    // row split only runs with a usable glyphs-per-row value
    a_per_row_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && !fits_row0) |-> (per_row_reg != '0))
        else $error("glyphs per row is zero in the row split");

    // a drawn glyph leaves idle on the next cycle
    a_draw_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_entry.op == OP_DRAW) |=> (state_reg != ST_IDLE))
        else $error("draw entry popped without starting the split");

    // finishing a glyph always presents a result
    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_free) |=> out_valid_reg)
        else $error("result lost at the output register");

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the glyph blit address generator
`timescale 1ns / 1ps

module tb;
    import gbag_pkg::*;

    localparam int CLK_HALF_NS   = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 80;
    localparam int LONG_HOLD     = 400;
    localparam int TIMEOUT_NS    = 10_000_000;

    // the fourth command code has no meaning and must be dropped
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predicted block state
    logic [7:0]  cell_w = CELL_WIDTH_RST;
    logic [7:0]  cell_h = CELL_HEIGHT_RST;
    logic [11:0] atlas_w = ATLAS_WIDTH_RST;
    logic [15:0] glyph_map [0:CODE_COUNT-1];
    logic [31:0] pen_x = '0;
    logic [31:0] pen_y = '0;
    logic [31:0] line_x = '0;

    // blits predicted but not yet seen on the output
    result_t pending_blits [$];

    int  feed_gap_pct = 0;
    int  drain_stall_pct = 0;
    bit  hold_req = 1'b0;
    int  mismatches = 0;
    int  items_effective = 0;
    int  blits_checked = 0;
    int  settings_used = 0;

    glyph_blit_address_generator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always #(CLK_HALF_NS) clk = ~clk;

    // output ready: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin : blit_sink
        int hold_left;
        bit hold_seen;
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= drain_stall_pct);
        end
    end

    // compare each output transfer with the oldest predicted blit
    always @(posedge clk)
    begin : blit_check
        result_t seen;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
            if (pending_blits.size() == 0)
            begin
                $error("blit transfer with nothing predicted: %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_blits.pop_front();
                blits_checked++;
                if (seen.src_x !== want.src_x)
                begin
                    $error("src_x: expected %0d, got %0d", want.src_x, seen.src_x);
                    mismatches++;
                end
                if (seen.src_y !== want.src_y)
                begin
                    $error("src_y: expected %0d, got %0d", want.src_y, seen.src_y);
                    mismatches++;
                end
                if (seen.dst_x !== want.dst_x)
                begin
                    $error("dst_x: expected %0d, got %0d",
                           $signed(want.dst_x), $signed(seen.dst_x));
                    mismatches++;
                end
                if (seen.dst_y !== want.dst_y)
                begin
                    $error("dst_y: expected %0d, got %0d",
                           $signed(want.dst_y), $signed(seen.dst_y));
                    mismatches++;
                end
            end
        end
    end

    // update the predicted state for one accepted item, queue its blit if any
    task automatic apply_item(input logic [1:0] cmd, input logic [15:0] code,
                              input logic [15:0] glyph, input logic [15:0] ox,
                              input logic [15:0] oy);
        logic [15:0] key;
        int unsigned g;
        int unsigned tw;
        int unsigned fw;
        int unsigned per_row;
        int unsigned first_wrap;
        int unsigned rows;
        int unsigned col;
        result_t blit;
        key = code;
        case (cmd)
            CMD_LOAD:
            begin
                if (key != CH_NEWLINE && key != CODE_MASK)
                begin
                    glyph_map[key] = glyph;
                    items_effective++;
                end
            end
            CMD_START:
            begin
                pen_x = {{16{ox[15]}}, ox};
                pen_y = {{16{oy[15]}}, oy};
                line_x = pen_x;
                items_effective++;
            end
            CMD_CHAR:
            begin
                items_effective++;
                if (key == CH_NEWLINE)
                begin
                    pen_y = pen_y + {24'd0, cell_h};
                    pen_x = line_x;
                end
                else if (key == CH_TAB)
                begin
                    pen_x = pen_x + ({24'd0, cell_w} << 1);
                end
                else
                begin
                    if (key >= FOLD_LOW && key <= FOLD_HIGH)
                    begin
                        key = key - FOLD_STEP;
                    end
                    // split the glyph number into atlas column and row
                    g = glyph_map[key];
                    tw = cell_w;
                    fw = (atlas_w == 0) ? 1 : atlas_w;
                    if (tw == 0 || g * tw < fw)
                    begin
                        col = g;
                        rows = 0;
                    end
                    else
                    begin
                        per_row = fw / tw;
                        if (per_row == 0)
                        begin
                            per_row = 1;
                        end
                        first_wrap = (fw + tw - 1) / tw;
                        rows = (g - first_wrap) / per_row + 1;
                        col = g - rows * per_row;
                    end
                    pen_x = pen_x + {24'd0, cell_w};
                    blit.src_x = 12'(col * tw);
                    blit.src_y = 24'(rows * cell_h);
                    blit.dst_x = pen_x;
                    blit.dst_y = pen_y;
                    pending_blits.insert(pending_blits.size(), blit);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // offer one item after a random gap and wait for its transfer
    task automatic send_item(input logic [1:0] cmd, input logic [15:0] code,
                             input logic [15:0] glyph, input logic [15:0] ox,
                             input logic [15:0] oy);
        while ($urandom_range(99) < feed_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tuser <= cmd;
        s_axis_tdata <= {oy, ox, glyph, code};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_item(cmd, code, glyph, ox, oy);
    endtask

    // stop offering, wait for every predicted blit, then let the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_blits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all three cell registers back to back
    task automatic write_cell_regs(input logic [11:0] cw, input logic [11:0] ch,
                                   input logic [11:0] aw);
        cfg_we <= 1'b1;
        cfg_index <= REG_CELL_WIDTH;
        cfg_data <= cw;
        @(posedge clk);
        cfg_index <= REG_CELL_HEIGHT;
        cfg_data <= ch;
        @(posedge clk);
        cfg_index <= REG_ATLAS_WIDTH;
        cfg_data <= aw;
        @(posedge clk);
        cfg_we <= 1'b0;
        cell_w = cw[7:0];
        cell_h = ch[7:0];
        atlas_w = aw;
        settings_used++;
    endtask

    // mostly small glyph numbers, some anywhere in the 16-bit range
    function automatic logic [15:0] pick_glyph();
        if ($urandom_range(99) < 60)
        begin
            return 16'($urandom_range(600));
        end
        return 16'($urandom());
    endfunction

    // hand-picked items at reset settings
    task automatic test_directed_cases();
        send_item(CMD_LOAD, 16'h0041, 16'd0, 16'h0000, 16'h0000);
        send_item(CMD_LOAD, 16'h0042, 16'd33, 16'h0000, 16'h0000);
        send_item(CMD_LOAD, 16'h0410, 16'hFFFF, 16'h0000, 16'h0000);
        send_item(CMD_LOAD, 16'h0000, 16'd5, 16'h0000, 16'h0000);
        // loads of the all-ones code and of newline leave the table alone
        send_item(CMD_LOAD, 16'hFFFF, 16'h1234, 16'hFFFF, 16'hFFFF);
        send_item(CMD_LOAD, CH_NEWLINE, 16'h0777, 16'h0000, 16'h0000);
        send_item(CMD_LOAD, CH_TAB, 16'd2, 16'h0000, 16'h0000);
        send_item(CMD_START, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
        send_item(CMD_CHAR, 16'h0041, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_CHAR, 16'h0042, 16'h0000, 16'h0000, 16'h0000);
        // folded code lands on the entry loaded at 0x410
        send_item(CMD_CHAR, 16'h0430, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_CHAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_CHAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_CHAR, CH_TAB, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_CHAR, CH_NEWLINE, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_CHAR, 16'h044F, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_CHAR, 16'h0450, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_CHAR, 16'h042F, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_START, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000);
        send_item(CMD_CHAR, 16'h0041, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_CHAR, CH_NEWLINE, 16'h0000, 16'h0000, 16'h0000);
        send_item(CMD_LOAD, 16'h0041, 16'hFFFF, 16'h0000, 16'h0000);
        send_item(CMD_CHAR, 16'h0041, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // one register setting, then random strings over a small loaded code set
    task automatic run_text_segment(input logic [11:0] cw, input logic [11:0] ch,
                                    input logic [11:0] aw, input int count);
        logic [15:0] pool [16];
        logic [15:0] code;
        int unsigned pick;
        int base;
        settle();
        write_cell_regs(cw, ch, aw);
        foreach (pool[i])
        begin
            if (i < 4)
            begin
                pool[i] = 16'(FOLD_LOW - FOLD_STEP + $urandom_range(31));
            end
            else
            begin
                pool[i] = 16'($urandom());
            end
        end
        base = items_effective;
        foreach (pool[i])
        begin
            send_item(CMD_LOAD, pool[i], pick_glyph(), 16'($urandom()), 16'($urandom()));
        end
        send_item(CMD_START, 16'($urandom()), 16'($urandom()),
                  16'($urandom()), 16'($urandom()));
        while (items_effective - base < count)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                code = ($urandom_range(9) < 7) ? pool[$urandom_range(15)] : 16'($urandom());
                send_item(CMD_LOAD, code, pick_glyph(), 16'($urandom()), 16'($urandom()));
            end
            else if (pick < 18)
            begin
                send_item(CMD_START, 16'($urandom()), 16'($urandom()),
                          16'($urandom()), 16'($urandom()));
            end
            else if (pick < 96)
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                begin
                    code = pool[$urandom_range(15)];
                end
                else if (pick < 70)
                begin
                    code = CH_NEWLINE;
                end
                else if (pick < 78)
                begin
                    code = CH_TAB;
                end
                else if (pick < 86)
                begin
                    code = 16'(FOLD_LOW + $urandom_range(31));
                end
                else
                begin
                    code = 16'($urandom());
                end
                send_item(CMD_CHAR, code, 16'($urandom()), 16'($urandom()),
                          16'($urandom()));
            end
            else
            begin
                send_item(CMD_UNUSED, 16'($urandom()), 16'($urandom()),
                          16'($urandom()), 16'($urandom()));
            end
        end
    endtask

    // random strings under three handshake mixes and nine register settings
    task automatic test_random_text();
        feed_gap_pct = 38;
        drain_stall_pct <= 82;
        run_text_segment(12'd1, 12'd1, 12'd1, 220);
        run_text_segment(12'd255, 12'd255, 12'd4095, 220);
        run_text_segment(12'($urandom_range(1, 255)), 12'($urandom_range(1, 255)),
                         12'($urandom_range(1, 4095)), 220);
        feed_gap_pct = 82;
        drain_stall_pct <= 38;
        // zero cell width keeps every glyph in row zero
        run_text_segment(12'd0, 12'($urandom_range(1, 255)),
                         12'($urandom_range(1, 4095)), 220);
        // zero atlas width behaves as width one
        run_text_segment(12'($urandom_range(1, 255)), 12'($urandom_range(1, 255)),
                         12'd0, 220);
        run_text_segment(12'd255, 12'd1, 12'd1, 220);
        feed_gap_pct = 0;
        drain_stall_pct <= 0;
        run_text_segment(12'd7, 12'd200, 12'd100, 220);
        run_text_segment(12'($urandom_range(1, 255)), 12'($urandom_range(1, 255)),
                         12'($urandom_range(1, 4095)), 220);
        run_text_segment(12'd8, 12'd8, 12'd256, 220);
    endtask

    // hold the output off for a long stretch while items keep coming
    task automatic test_output_stall();
        settle();
        feed_gap_pct = 0;
        drain_stall_pct <= 0;
        hold_req <= ~hold_req;
        send_item(CMD_START, 16'h0000, 16'h0000, 16'($urandom()), 16'($urandom()));
        repeat (40)
        begin
            send_item(CMD_CHAR, ($urandom_range(1) != 0) ? 16'h0041 : 16'($urandom()),
                      16'h0000, 16'h0000, 16'h0000);
        end
    endtask

    // run the tests in turn
    initial
    begin
        foreach (glyph_map[i])
        begin
            glyph_map[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_random_text();
        test_output_stall();
        settle();
        $display("covered %0d text items and %0d checked blits", items_effective,
                 blits_checked);
        $display("over %0d register settings, three handshake mixes and a long stall",
                 settings_used);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("watchdog expired with %0d blits outstanding", pending_blits.size());
        $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/gbag_pkg.sv
hw/rtl/gbag_div.sv
hw/rtl/gbag_front.sv
hw/rtl/gbag_queue.sv
hw/rtl/gbag_back.sv
hw/rtl/glyph_blit_address_generator.sv
dv/tb.sv
